/* sv/ttpe_pkg.sv */
package ttpe_pkg;

	localparam logic [6:0] BASE_CHAR  = 7'h60;
	localparam logic [6:0] END_MARK   = 7'h7B;
	localparam logic [6:0] PAD_MARK   = 7'h7D;
	localparam logic [6:0] SPACE_CHAR = 7'h20;
	localparam logic [6:0] DOT_CHAR   = 7'h2E;
	localparam logic [6:0] DOT_CODE   = 7'h7C;
	localparam logic [7:0] LF_BYTE    = 8'd10;

	typedef struct packed {
		logic [6:0] text_char;
		logic       line_last;
	} char_beat_t;

	typedef struct packed {
		logic signed [15:0] code_word;
		logic               line_done;
	} word_beat_t;

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} sym_t;

	typedef struct packed {
		logic valid;
		sym_t sym;
	} queue_head_t;

	typedef enum logic [1:0] {
		FLUSH_NONE,
		FLUSH_END,
		FLUSH_PAD
	} flush_t;

endpackage

/* sv/ttpe_front.sv */
module ttpe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  char_valid,
	output logic                  char_stall,
	input  ttpe_pkg::char_beat_t  char_beat,
	output ttpe_pkg::queue_head_t head,
	input  logic                  pop
);
	import ttpe_pkg::*;

	sym_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	sym_t       mapped;

	always_comb begin
		mapped.last = char_beat.line_last;
		case (char_beat.text_char)
			SPACE_CHAR: mapped.ch = BASE_CHAR;
			DOT_CHAR:   mapped.ch = DOT_CODE;
			default:    mapped.ch = char_beat.text_char;
		endcase
	end

	assign char_stall = (count_q == 2'd2);
	assign push       = char_valid && !char_stall;
	assign head.valid = (count_q != 2'd0);
	assign head.sym   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= mapped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/ttpe_back.sv */
module ttpe_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ttpe_pkg::queue_head_t head,
	output logic                  pop,
	output logic                  word_valid,
	input  logic                  word_stall,
	output ttpe_pkg::word_beat_t  word_beat
);
	import ttpe_pkg::*;

	logic [6:0] win0_q;
	logic [6:0] win1_q;
	logic [1:0] cnt_q;
	logic       drop_q;
	flush_t     flush_q;
	logic       out_valid_q;
	word_beat_t out_q;

	logic       have_sym;
	logic       adv;
	logic [6:0] sym;
	logic [14:0] triple;
	logic       use_pair;
	logic       emit;
	logic       done;
	word_beat_t word_d;

	always_comb begin
		sym      = head.sym.ch;
		have_sym = head.valid;
		case (flush_q)
			FLUSH_END: begin
				sym      = END_MARK;
				have_sym = 1'b1;
			end
			FLUSH_PAD: begin
				sym      = PAD_MARK;
				have_sym = 1'b1;
			end
			default: ;
		endcase
	end

	assign adv = have_sym && (!out_valid_q || !word_stall);
	assign pop = adv && (flush_q == FLUSH_NONE);

	always_comb begin
		triple   = {sym[4:0], win1_q[4:0], win0_q[4:0]};
		use_pair = !(win0_q[6] && win0_q[5]) || !(win1_q[6] && win1_q[5])
			|| !(sym[6] && sym[5]) || (triple[7:0] == LF_BYTE)
			|| ({1'b0, triple[14:8]} == LF_BYTE);
		emit = (cnt_q == 2'd2) && !(flush_q == FLUSH_NONE && drop_q);
		if (use_pair) begin
			word_d.code_word = -$signed({1'b0, win1_q, 1'b0, win0_q});
			done = (win0_q == END_MARK) || (win1_q == END_MARK);
		end else begin
			word_d.code_word = $signed({1'b0, triple});
			done = (win0_q == END_MARK) || (win1_q == END_MARK) || (sym == END_MARK);
		end
		word_d.line_done = done;
		done = done && emit;
	end

	assign word_valid = out_valid_q;
	assign word_beat  = out_q;

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			out_q <= word_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q      <= '0;
			win1_q      <= '0;
			cnt_q       <= 2'd0;
			drop_q      <= 1'b0;
			flush_q     <= FLUSH_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (adv && emit) begin
				out_valid_q <= 1'b1;
			end else if (!word_stall) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				if (flush_q == FLUSH_NONE && drop_q) begin
					if (head.sym.last) begin
						drop_q <= 1'b0;
					end
				end else begin
					if (done) begin
						cnt_q <= 2'd0;
						win0_q <= '0;
						win1_q <= '0;
					end else if (emit) begin
						if (use_pair) begin
							win0_q <= sym;
							win1_q <= '0;
							cnt_q  <= 2'd1;
						end else begin
							win0_q <= '0;
							win1_q <= '0;
							cnt_q  <= 2'd0;
						end
					end else if (cnt_q == 2'd0) begin
						win0_q <= sym;
						cnt_q  <= 2'd1;
					end else begin
						win1_q <= sym;
						cnt_q  <= 2'd2;
					end
					case (flush_q)
						FLUSH_NONE: begin
							if (done) begin
								drop_q <= !head.sym.last;
							end else if (head.sym.last) begin
								flush_q <= FLUSH_END;
							end
						end
						default: begin
							flush_q <= done ? FLUSH_NONE : FLUSH_PAD;
						end
					endcase
				end
			end
		end
	end

endmodule

/* sv/text_triple_pack_encoder.sv */
// Text triple-pack encoder.
// Input channel char_valid / char_stall / char_beat carries one 7-bit
// character per beat, line_last set on the final character of a line.
// Output channel word_valid / word_stall / word_beat carries 16-bit code
// words, line_done set on the last word of each line.
// A two-entry queue decouples the character side from the encoder; the
// encoder handles one character, or one appended '{' / '}' marker, per
// cycle unless a word is held by word_stall, so characters are taken one
// per cycle in steady state. At a line end the encoder spends its turns
// on the markers, during which the queue fills and char_stall rises.
// An accepted character passes through the queue, then the output
// register, into the word it completes.
// While word_stall is high and a word is waiting, the encoder holds; the
// queue keeps taking characters until both entries are full.
// Reset clears the queue, the window and the line-drop flag; no word is
// valid after reset.
module text_triple_pack_encoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_stall,
	input  ttpe_pkg::char_beat_t char_beat,
	output logic                 word_valid,
	input  logic                 word_stall,
	output ttpe_pkg::word_beat_t word_beat
);
	import ttpe_pkg::*;

	queue_head_t head;
	logic        pop;

	ttpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.head       (head),
		.pop        (pop)
	);

	ttpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_beat  (word_beat)
	);

endmodule

/* test/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ttpe_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 150;
	localparam int DRAIN_TAIL   = 10;
	localparam int RANDOM_ITEMS = 140;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       char_valid;
	logic       char_stall;
	char_beat_t char_beat;
	logic       word_valid;
	logic       word_stall;
	word_beat_t word_beat;

	text_triple_pack_encoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_beat  (word_beat)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	word_beat_t expected_words[$];
	logic [6:0] window_ch [3];
	int         window_fill;
	bit         drop_line;

	bit tx_idle;
	bit rx_idle;
	bit hold_req;

	int cycle_count;
	int chars_sent;
	int lines_sent;
	int words_checked;
	int mismatches;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at word %0d, %s: got %0d, expected %0d",
			words_checked, what, got, want);
		mismatches++;
	endtask

	task automatic clear_window();
		window_ch[0] = '0;
		window_ch[1] = '0;
		window_ch[2] = '0;
		window_fill  = 0;
	endtask

	task automatic pack_window(output bit ended);
		logic [6:0]  a, b, c;
		logic [6:0]  da, db, dc;
		logic [15:0] word;
		bit          pair;
		word_beat_t  wb;
		a = window_ch[0];
		b = window_ch[1];
		c = window_ch[2];
		pair = (a < BASE_CHAR) || (b < BASE_CHAR) || (c < BASE_CHAR);
		word = '0;
		if (!pair) begin
			da = a - BASE_CHAR;
			db = b - BASE_CHAR;
			dc = c - BASE_CHAR;
			word = {1'b0, dc[4:0], db[4:0], da[4:0]};
			if (word[7:0] == LF_BYTE || word[15:8] == LF_BYTE)
				pair = 1'b1;
		end
		if (pair) begin
			word = 16'd0 - ({9'd0, a} + {1'b0, b, 8'd0});
			ended = (a == END_MARK) || (b == END_MARK);
			window_ch[0] = c;
			window_ch[1] = '0;
			window_ch[2] = '0;
			window_fill  = 1;
		end else begin
			ended = (a == END_MARK) || (b == END_MARK) || (c == END_MARK);
			clear_window();
		end
		wb.code_word = word;
		wb.line_done = ended;
		expected_words.push_back(wb);
	endtask

	task automatic push_symbol(input logic [6:0] ch, inout int made, output bit ended);
		ended = 1'b0;
		if (window_fill > 2)
			window_fill = 2;
		window_ch[window_fill] = ch;
		window_fill++;
		if (window_fill == 3 && made < 3) begin
			pack_window(ended);
			made++;
		end
	endtask

	task automatic predict_char(input logic [6:0] ch_in, input logic last);
		logic [6:0] ch;
		int         made;
		bit         ended;
		int         k;
		made = 0;
		if (drop_line) begin
			if (last)
				drop_line = 1'b0;
			return;
		end
		ch = ch_in;
		if (ch == SPACE_CHAR)
			ch = BASE_CHAR;
		else if (ch == DOT_CHAR)
			ch = DOT_CODE;
		push_symbol(ch, made, ended);
		if (ended) begin
			clear_window();
			if (!last)
				drop_line = 1'b1;
			return;
		end
		if (!last)
			return;
		push_symbol(END_MARK, made, ended);
		for (k = 0; k < 3 && !ended; k++)
			push_symbol(PAD_MARK, made, ended);
		clear_window();
	endtask

	task automatic send_char(input logic [6:0] ch, input logic last);
		int         gap;
		char_beat_t beat;
		gap = tx_idle ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		beat.text_char = ch;
		beat.line_last = last;
		char_valid <= 1'b1;
		char_beat  <= beat;
		do @(posedge clk); while (char_stall !== 1'b0);
		predict_char(ch, last);
		chars_sent++;
		if (last)
			lines_sent++;
	endtask

	task automatic send_text(input string s);
		byte b;
		int  i;
		for (i = 0; i < s.len(); i++) begin
			b = s[i];
			send_char(b[6:0], i == s.len() - 1);
		end
	endtask

	function automatic logic [6:0] pick_char(input bit noisy);
		int r;
		r = $urandom_range(0, 99);
		if (noisy || r >= 90)
			return 7'($urandom_range(0, 127));
		if (r < 60)
			return 7'($urandom_range(97, 122));
		if (r < 72)
			return SPACE_CHAR;
		if (r < 80)
			return DOT_CHAR;
		if (r < 84)
			return END_MARK;
		return 7'($urandom_range(96, 126));
	endfunction

	task automatic send_line(input int len, input bit noisy);
		int i;
		for (i = 0; i < len; i++)
			send_char(pick_char(noisy), i == len - 1);
	endtask

	task automatic wait_drained();
		char_valid <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	task automatic test_directed_cases();
		send_text("abc");
		send_text("apb");
		send_text("j`a");
		send_text("a b.");
		send_char(7'h00, 1'b0);
		send_char(7'h7F, 1'b0);
		send_char(7'h78, 1'b1);
		send_text("a{bcd");
		send_text("a{b");
		send_text("z");
	endtask

	task automatic test_back_to_back();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		while (chars_sent < 60)
			send_line($urandom_range(1, 8), 1'b0);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_output_hold_off();
		int i;
		tx_idle  = 1'b0;
		hold_req = 1'b1;
		for (i = 0; i < 3; i++)
			send_line(8, 1'b0);
		tx_idle = 1'b1;
		wait_drained();
	endtask

	task automatic test_drain_between_lines();
		int i;
		for (i = 0; i < 4; i++) begin
			send_line($urandom_range(1, 12), 1'b0);
			wait_drained();
		end
	endtask

	task automatic test_random_lines();
		int target;
		target = chars_sent + RANDOM_ITEMS;
		while (chars_sent < target) begin
			if ($urandom_range(0, 9) == 0)
				send_line($urandom_range(11, 24), $urandom_range(0, 9) == 0);
			else
				send_line($urandom_range(1, 10), $urandom_range(0, 9) == 0);
		end
	endtask

	initial begin : recv_side
		int n;
		word_stall = 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				word_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				n = rx_idle ? $urandom_range(0, 16) : 0;
				if (n > 0) begin
					word_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			word_stall <= 1'b0;
			do @(posedge clk); while (word_valid !== 1'b1 && !hold_req);
		end
	end

	always @(posedge clk) begin : check_words
		word_beat_t want;
		if (arst_n === 1'b1 && word_valid === 1'b1 && word_stall === 1'b0) begin
			if (expected_words.size() == 0) begin
				report_mismatch("word with nothing pending", word_beat.code_word, 0);
			end else begin
				want = expected_words.pop_front();
				if (word_beat.code_word !== want.code_word)
					report_mismatch("code_word", word_beat.code_word, want.code_word);
				if (word_beat.line_done !== want.line_done)
					report_mismatch("line_done", word_beat.line_done, want.line_done);
			end
			words_checked++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_beat  = '0;
		tx_idle    = 1'b1;
		rx_idle    = 1'b1;
		hold_req   = 1'b0;
		drop_line  = 1'b0;
		clear_window();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_back_to_back();
		test_output_hold_off();
		test_drain_between_lines();
		test_random_lines();
		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		$display("Sent %0d characters in %0d lines, with idle gaps, hold-off and drains;",
			chars_sent, lines_sent);
		$display("compared %0d code words, %0d mismatches.", words_checked, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
